/* hw/rtl/kmsr_pkg.sv */
// ----------------------------------------------------------------------------
// kmsr_pkg
// Shared types, constants and character tables for the key matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsr_pkg;

    // Matrix geometry
    localparam int unsigned ROWS       = 8;
    localparam int unsigned COLUMNS    = 6;
    localparam int unsigned MATRIX_W   = ROWS * COLUMNS;
    localparam int unsigned ROW_IDX_W  = $clog2(ROWS);
    localparam int unsigned COL_IDX_W  = 3;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;

    // Modifier and special key positions
    localparam logic [ROW_IDX_W-1:0] SHIFT_ROW = 3'd1;
    localparam logic [ROW_IDX_W-1:0] CTRL_ROW  = 3'd2;
    localparam int unsigned          MOD_BIT   = 3;
    localparam logic [ROW_IDX_W-1:0] ENTER_ROW = 3'd6;
    localparam logic [COL_IDX_W-1:0] ENTER_COL = 3'd2;

    // Character constants
    localparam logic [CHAR_W-1:0] CH_SEMI      = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [CHAR_W-1:0] CTRL_MASK    = 8'h1F;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE_CODE = 3'd3;

    // Configuration reset values
    localparam logic [CHAR_W-1:0] FIRST_DELAY_RST    = 8'd32;
    localparam logic [CHAR_W-1:0] REPEAT_DELAY_RST   = 8'd4;
    localparam logic [CHAR_W-1:0] ENTER_CODE_RST     = 8'd13;
    localparam logic [CHAR_W-1:0] BACKSPACE_CODE_RST = 8'd8;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Status from the row scanner to the controller
    typedef struct packed {
        logic                 busy;
        logic                 fresh;
        logic [COUNT_W-1:0]   keys_held;
        logic [ROW_IDX_W-1:0] last_row;
        logic [COL_IDX_W-1:0] last_col;
        logic                 shift;
        logic                 ctrl;
    } t_scan_status;

    typedef logic [CHAR_W-1:0] t_char_row [COLUMNS];
    typedef t_char_row         t_char_map [ROWS];

    // Unshifted characters, indexed by row then column.
    localparam t_char_map PLAIN_MAP = '{
        '{8'h74, 8'h77, 8'h00, 8'h65, 8'h71, 8'h72},
        '{8'h67, 8'h73, 8'h00, 8'h64, 8'h61, 8'h66},
        '{8'h62, 8'h78, 8'h00, 8'h63, 8'h7A, 8'h76},
        '{8'h35, 8'h32, 8'h00, 8'h33, 8'h31, 8'h34},
        '{8'h6E, 8'h2E, 8'h00, 8'h2C, 8'h20, 8'h6D},
        '{8'h36, 8'h39, 8'h2D, 8'h38, 8'h30, 8'h37},
        '{8'h79, 8'h6F, 8'h00, 8'h69, 8'h70, 8'h75},
        '{8'h68, 8'h6C, 8'h3A, 8'h6B, 8'h3B, 8'h6A}
    };

    // Shifted characters, indexed by row then column.
    localparam t_char_map SHIFTED_MAP = '{
        '{8'h74, 8'h77, 8'h00, 8'h65, 8'h71, 8'h72},
        '{8'h67, 8'h73, 8'h00, 8'h64, 8'h61, 8'h66},
        '{8'h62, 8'h78, 8'h00, 8'h63, 8'h7A, 8'h76},
        '{8'h25, 8'h22, 8'h00, 8'h23, 8'h21, 8'h24},
        '{8'h5E, 8'h3E, 8'h00, 8'h3C, 8'h20, 8'h5C},
        '{8'h26, 8'h29, 8'h3D, 8'h28, 8'h40, 8'h27},
        '{8'h7E, 8'h5B, 8'h00, 8'h7D, 8'h5D, 8'h7B},
        '{8'h68, 8'h3F, 8'h2A, 8'h2F, 8'h2B, 8'h7C}
    };

endpackage

`default_nettype wire

/* hw/rtl/kmsr_row_scan.sv */
// ----------------------------------------------------------------------------
// kmsr_row_scan
// Row-serial comparison of the new matrix against the previous one. One
// six-bit row is taken from a shift register each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsr_row_scan (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [kmsr_pkg::MATRIX_W-1:0]     i_key_matrix,
    output kmsr_pkg::t_scan_status                 o_status
);

    localparam int unsigned RW = kmsr_pkg::COLUMNS;
    localparam int unsigned MW = kmsr_pkg::MATRIX_W;
    localparam int unsigned PW = $clog2(kmsr_pkg::COLUMNS + 1);

    logic [MW-1:0]                  r_cur;
    logic [MW-1:0]                  r_prev;
    logic [kmsr_pkg::ROW_IDX_W-1:0] r_row;
    logic                           r_busy;
    logic                           r_fresh;
    logic [kmsr_pkg::COUNT_W-1:0]   r_keys_held;
    logic [kmsr_pkg::ROW_IDX_W-1:0] r_last_row;
    logic [kmsr_pkg::COL_IDX_W-1:0] r_last_col;

    logic [RW-1:0]                  now_bits;
    logic [RW-1:0]                  before_bits;
    logic [RW-1:0]                  mod_mask;
    logic [RW-1:0]                  diff;
    logic [RW-1:0]                  press;
    logic [RW-1:0]                  release_bits;
    logic [PW-1:0]                  press_cnt;
    logic [PW-1:0]                  release_cnt;
    logic                           any_press;
    logic [kmsr_pkg::COL_IDX_W-1:0] press_col;
    logic [kmsr_pkg::COUNT_W-1:0]   n_keys_held;

    // Differences within the current row, with modifier keys masked out.
    always_comb begin
        now_bits     = r_cur[RW-1:0];
        before_bits  = r_prev[RW-1:0];
        mod_mask     = '0;
        if (r_row == kmsr_pkg::SHIFT_ROW || r_row == kmsr_pkg::CTRL_ROW) begin
            mod_mask[kmsr_pkg::MOD_BIT] = 1'b1;
        end
        diff         = (now_bits ^ before_bits) & ~mod_mask;
        press        = diff & now_bits;
        release_bits = diff & before_bits;
    end

    // Count presses and releases, and find the last new press in scan order.
    // Scan order runs from the high bit down, so the lowest set bit wins.
    always_comb begin
        press_cnt   = '0;
        release_cnt = '0;
        any_press   = 1'b0;
        press_col   = '0;
        for (int b = RW - 1; b >= 0; b--) begin
            press_cnt   = press_cnt + PW'(press[b]);
            release_cnt = release_cnt + PW'(release_bits[b]);
            if (press[b]) begin
                any_press = 1'b1;
                press_col = kmsr_pkg::COL_IDX_W'(RW - 1 - b);
            end
        end
        n_keys_held = r_keys_held
                    + kmsr_pkg::COUNT_W'(press_cnt)
                    - kmsr_pkg::COUNT_W'(release_cnt);
    end

    // Control state of the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_fresh     <= 1'b0;
            r_keys_held <= '0;
            r_last_row  <= '0;
            r_last_col  <= '0;
            r_prev      <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_row   <= '0;
            r_fresh <= 1'b0;
        end else if (r_busy) begin
            r_row       <= r_row + 1'b1;
            r_keys_held <= n_keys_held;
            r_prev      <= {now_bits, r_prev[MW-1:RW]};
            if (r_row == kmsr_pkg::ROW_IDX_W'(kmsr_pkg::ROWS - 1)) begin
                r_busy <= 1'b0;
            end
            if (any_press) begin
                r_fresh    <= 1'b1;
                r_last_row <= r_row;
                r_last_col <= press_col;
            end
        end
    end

    // New matrix shifts out one row per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur <= i_key_matrix;
        end else if (r_busy) begin
            r_cur <= r_cur >> RW;
        end
    end

    always_comb begin
        o_status.busy      = r_busy;
        o_status.fresh     = r_fresh;
        o_status.keys_held = r_keys_held;
        o_status.last_row  = r_last_row;
        o_status.last_col  = r_last_col;
        o_status.shift     = r_prev[int'(kmsr_pkg::SHIFT_ROW) * RW + kmsr_pkg::MOD_BIT];
        o_status.ctrl      = r_prev[int'(kmsr_pkg::CTRL_ROW) * RW + kmsr_pkg::MOD_BIT];
    end

endmodule

`default_nettype wire

/* hw/rtl/kmsr_decode.sv */
// ----------------------------------------------------------------------------
// kmsr_decode
// Character decode of the remembered key, with shift and ctrl applied.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsr_decode (
    input  wire logic [kmsr_pkg::ROW_IDX_W-1:0] i_row,
    input  wire logic [kmsr_pkg::COL_IDX_W-1:0] i_col,
    input  wire logic                           i_shift,
    input  wire logic                           i_ctrl,
    input  wire logic [kmsr_pkg::CHAR_W-1:0]    i_enter_code,
    input  wire logic [kmsr_pkg::CHAR_W-1:0]    i_backspace_code,
    output logic      [kmsr_pkg::CHAR_W-1:0]    o_char
);

    logic                        is_enter;
    logic                        col_ok;
    logic [kmsr_pkg::CHAR_W-1:0] plain_ch;
    logic [kmsr_pkg::CHAR_W-1:0] shifted_ch;

    // Table lookup; the enter key takes its code from a register.
    always_comb begin
        is_enter   = (i_row == kmsr_pkg::ENTER_ROW) && (i_col == kmsr_pkg::ENTER_COL);
        col_ok     = (i_col < kmsr_pkg::COL_IDX_W'(kmsr_pkg::COLUMNS));
        plain_ch   = '0;
        shifted_ch = '0;
        if (col_ok) begin
            plain_ch   = kmsr_pkg::PLAIN_MAP[i_row][i_col];
            shifted_ch = kmsr_pkg::SHIFTED_MAP[i_row][i_col];
        end
        if (is_enter) begin
            plain_ch   = i_enter_code;
            shifted_ch = i_enter_code;
        end
    end

    // Modifier handling.
    always_comb begin
        priority if (i_ctrl && i_shift) begin
            if (plain_ch == kmsr_pkg::CH_SEMI) begin
                o_char = i_backspace_code;
            end else begin
                o_char = plain_ch & kmsr_pkg::CTRL_MASK;
            end
        end else if (i_ctrl) begin
            if (plain_ch >= kmsr_pkg::CH_LOWER_A && plain_ch <= kmsr_pkg::CH_LOWER_Z) begin
                o_char = plain_ch - kmsr_pkg::CASE_OFFSET;
            end else begin
                o_char = plain_ch;
            end
        end else if (i_shift) begin
            o_char = shifted_ch;
        end else begin
            o_char = plain_ch;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/key_matrix_scanner_repeat_unit.sv */
// ----------------------------------------------------------------------------
// key_matrix_scanner_repeat_unit
// Keyboard matrix scanner with auto-repeat: compares each scan with the last
// one row by row, tracks held keys and emits decoded characters.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  -------------------------
//  in        sink       i_in_valid / o_in_stall    i_key_matrix [47:0]
//  out       source     o_out_valid / i_out_stall  o_char_code [7:0]
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  From acceptance to the result register a scan goes through the row scanner,
//  one row of the matrix per cycle, then through a hand-over step and the
//  repeat decision.
//  A scan that produces no character still goes through the same steps.
//  The input stays stalled until the decision is made, so the next scan is
//  accepted in the cycle after it, even while a character is still held in
//  the output register.
//  If the output register is full and stalled, a decision that emits waits for it.
//  Reset restores the configuration defaults and clears all key state.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_scanner_repeat_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Scan input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [kmsr_pkg::MATRIX_W-1:0]     i_key_matrix,
    // Character output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [kmsr_pkg::CHAR_W-1:0]       o_char_code,
    // Configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kmsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kmsr_pkg::CHAR_W-1:0]       i_cfg_data
);

    kmsr_pkg::t_state       r_state;
    kmsr_pkg::t_state       n_state;
    kmsr_pkg::t_scan_status scan_st;

    logic [kmsr_pkg::CHAR_W-1:0] r_first_delay;
    logic [kmsr_pkg::CHAR_W-1:0] r_repeat_delay;
    logic [kmsr_pkg::CHAR_W-1:0] r_enter_code;
    logic [kmsr_pkg::CHAR_W-1:0] r_backspace_code;
    logic [kmsr_pkg::CHAR_W-1:0] r_timer;
    logic [kmsr_pkg::CHAR_W-1:0] n_timer;
    logic                        r_out_valid;
    logic [kmsr_pkg::CHAR_W-1:0] r_char;
    logic [kmsr_pkg::CHAR_W-1:0] dec_char;

    logic                        in_accept;
    logic                        out_free;
    logic                        held_ok;
    logic [kmsr_pkg::CHAR_W-1:0] timer_dec;
    logic                        emit;
    logic                        decide;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    kmsr_row_scan u_row_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_accept),
        .i_key_matrix (i_key_matrix),
        .o_status     (scan_st)
    );

    kmsr_decode u_decode (
        .i_row            (scan_st.last_row),
        .i_col            (scan_st.last_col),
        .i_shift          (scan_st.shift),
        .i_ctrl           (scan_st.ctrl),
        .i_enter_code     (r_enter_code),
        .i_backspace_code (r_backspace_code),
        .o_char           (dec_char)
    );

    // Repeat decision once the whole matrix has been compared.
    always_comb begin
        held_ok   = (scan_st.keys_held != '0)
                 && (scan_st.keys_held < kmsr_pkg::COUNT_W'(3));
        timer_dec = r_timer - 1'b1;
        emit      = 1'b0;
        n_timer   = r_timer;
        if (held_ok) begin
            if (scan_st.fresh) begin
                emit    = 1'b1;
                n_timer = r_first_delay;
            end else if (timer_dec == '0) begin
                emit    = 1'b1;
                n_timer = r_repeat_delay;
            end else begin
                n_timer = timer_dec;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmsr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = kmsr_pkg::ST_SCAN;
                end
            end
            kmsr_pkg::ST_SCAN: begin
                if (!scan_st.busy) begin
                    n_state = kmsr_pkg::ST_DONE;
                end
            end
            kmsr_pkg::ST_DONE: begin
                if (!emit || out_free) begin
                    n_state = kmsr_pkg::ST_IDLE;
                end
            end
            default: n_state = kmsr_pkg::ST_IDLE;
        endcase
    end

    // State outputs; the input is held off while reset is applied.
    always_comb begin
        o_in_stall = 1'b1;
        decide     = 1'b0;
        unique case (r_state)
            kmsr_pkg::ST_IDLE: o_in_stall = !i_rst_n;
            kmsr_pkg::ST_SCAN: o_in_stall = 1'b1;
            kmsr_pkg::ST_DONE: decide     = !emit || out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    // State register and repeat timer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmsr_pkg::ST_IDLE;
            r_timer <= '0;
        end else begin
            r_state <= n_state;
            if (decide) begin
                r_timer <= n_timer;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay    <= kmsr_pkg::FIRST_DELAY_RST;
            r_repeat_delay   <= kmsr_pkg::REPEAT_DELAY_RST;
            r_enter_code     <= kmsr_pkg::ENTER_CODE_RST;
            r_backspace_code <= kmsr_pkg::BACKSPACE_CODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kmsr_pkg::CFG_FIRST_DELAY:    r_first_delay    <= i_cfg_data;
                kmsr_pkg::CFG_REPEAT_DELAY:   r_repeat_delay   <= i_cfg_data;
                kmsr_pkg::CFG_ENTER_CODE:     r_enter_code     <= i_cfg_data;
                kmsr_pkg::CFG_BACKSPACE_CODE: r_backspace_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (decide && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decide && emit) begin
            r_char <= dec_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_cfg_ready = 1'b1;

    // An accepted scan always starts the row scanner.
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == kmsr_pkg::ST_SCAN) && scan_st.busy)
        else $error("accepted scan did not start the row scanner");

    // A character only appears after a repeat decision.
    a_out_from_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == kmsr_pkg::ST_DONE)
        else $error("output became valid outside a decision");

    // The held-key count can never exceed the number of non-modifier keys.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_st.keys_held <= kmsr_pkg::COUNT_W'(kmsr_pkg::MATRIX_W - 2))
        else $error("held-key count out of range");

    // The decision never overwrites a character that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (decide && emit) |-> out_free)
        else $error("pending character overwritten");

endmodule

`default_nettype wire
